>>> rtl/ohtlp_pkg.sv
// ----------------------------------------------------------------------------
// ohtlp_pkg
// Shared widths, codes and state types of the opcode hash table.
// ----------------------------------------------------------------------------
package ohtlp_pkg;

    localparam int CAPACITY_DEFAULT      = 64;
    localparam int MAX_KEY_CHARS_DEFAULT = 8;

    localparam int CMD_W        = 2;
    localparam int KEY_CHARS_W  = 64;
    localparam int KEY_LENGTH_W = 4;
    localparam int OPCODE_W     = 16;
    localparam int CODE_LEN_W   = 4;
    localparam int STATUS_W     = 2;

    localparam int CHAR_W     = 8;
    localparam int KEY_BYTES  = KEY_CHARS_W / CHAR_W;
    localparam int HASH_W     = 64;
    localparam int HASH_BYTES = HASH_W / CHAR_W;

    localparam int LOAD_LIMIT_W = 7;
    localparam logic [LOAD_LIMIT_W-1:0] LOAD_LIMIT_RESET = 7'd51;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_LOAD_LIMIT = 1'b0;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } top_state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_HASH,
        HS_MOD
    } hash_state_t;

endpackage

>>> rtl/ohtlp_ram.sv
// ----------------------------------------------------------------------------
// ohtlp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ohtlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ohtlp_hash.sv
// ----------------------------------------------------------------------------
// ohtlp_hash
// Multiplicative string hash, one character a cycle, then reduction of the
// 64-bit hash to a home slot index.
// ----------------------------------------------------------------------------
module ohtlp_hash #(
    parameter int CAPACITY      = ohtlp_pkg::CAPACITY_DEFAULT,
    parameter int MAX_KEY_CHARS = ohtlp_pkg::MAX_KEY_CHARS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ohtlp_pkg::CHAR_W*MAX_KEY_CHARS-1:0] key,
    input  logic [$clog2(MAX_KEY_CHARS+1)-1:0]   len,
    output logic                                 done,
    output logic [$clog2(CAPACITY)-1:0]          home
);

    import ohtlp_pkg::*;

    localparam int KEY_W = CHAR_W * MAX_KEY_CHARS;
    localparam int LEN_W = $clog2(MAX_KEY_CHARS + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int DIG_W = $clog2(HASH_BYTES);
    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [IDX_W:0] CAP_V = (IDX_W+1)'(CAPACITY);
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(HASH_BYTES - 1);

    hash_state_t       state_reg, state_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  home_reg, home_next;
    logic              done_reg, done_next;

    logic [IDX_W-1:0]  rem_step;
    logic [IDX_W:0]    trial;
    logic [CHAR_W-1:0] top_byte;
    logic              hash_last;

    assign hash_last = (idx_reg == len_reg);
    assign top_byte  = h_reg[HASH_W-1 -: CHAR_W];

    // Remainder of the running value after shifting in the next hash byte,
    // one restoring step per bit.
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = CHAR_W - 1; i >= 0; i--)
        begin
            trial = {rem_step, top_byte[i]};
            if (trial >= CAP_V)
            begin
                trial = trial - CAP_V;
            end
            rem_step = trial[IDX_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    state_next = HS_HASH;
                end
            end
            HS_HASH:
            begin
                if (hash_last)
                begin
                    state_next = IS_POW2 ? HS_IDLE : HS_MOD;
                end
            end
            HS_MOD:
            begin
                if (dig_reg == DIG_LAST)
                begin
                    state_next = HS_IDLE;
                end
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        h_next    = h_reg;
        key_next  = key_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        dig_next  = dig_reg;
        rem_next  = rem_reg;
        home_next = home_reg;
        done_next = 1'b0;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    h_next   = '0;
                    key_next = key;
                    len_next = len;
                    idx_next = '0;
                end
            end
            HS_HASH:
            begin
                if (hash_last)
                begin
                    dig_next = '0;
                    rem_next = '0;
                    if (IS_POW2)
                    begin
                        home_next = h_reg[IDX_W-1:0];
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    // h * 31 is (h << 5) - h, modulo 2^64.
                    h_next   = (h_reg << 5) - h_reg + HASH_W'(key_reg[CHAR_W-1:0]);
                    key_next = key_reg >> CHAR_W;
                    idx_next = idx_reg + LEN_W'(1);
                end
            end
            HS_MOD:
            begin
                rem_next = rem_step;
                h_next   = h_reg << CHAR_W;
                dig_next = dig_reg + DIG_W'(1);
                if (dig_reg == DIG_LAST)
                begin
                    home_next = rem_step;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        key_reg  <= key_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        dig_reg  <= dig_next;
        rem_reg  <= rem_next;
        home_reg <= home_next;
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

>>> rtl/opcode_hash_table_linear_probe.sv
// ----------------------------------------------------------------------------
// opcode_hash_table_linear_probe
// Open-addressing opcode table with linear probing, held in one slot RAM.
// ----------------------------------------------------------------------------
// Usage:
// A command word (command, key_chars, key_length, opcode_value, code_length)
// is taken at a rising edge where start is high and busy is low. Commands are
// insert, find and remove. Each command yields exactly one result word
// (status, found_opcode, found_length), shown for one cycle with done high;
// the receiver cannot stall, so nothing backs up behind a result.
// A new command is taken only after the previous one has finished. The hash
// unit takes one character a cycle of the clamped key; when CAPACITY is not
// a power of two, the reduction to a home slot then takes one hash byte a
// cycle. Probing reads one slot a cycle from the slot RAM. done is registered
// from the finish step, which follows the last slot check and updates the
// RAM; while done is high, busy is already low.
// After reset the block sweeps the slot RAM clear, one slot a cycle, with busy
// high. load_limit is written through the APB port, which is always ready,
// and should only be changed while idle.
// ----------------------------------------------------------------------------
module opcode_hash_table_linear_probe #(
    parameter int CAPACITY      = ohtlp_pkg::CAPACITY_DEFAULT,
    parameter int MAX_KEY_CHARS = ohtlp_pkg::MAX_KEY_CHARS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ohtlp_pkg::CMD_W-1:0]        command,
    input  logic [ohtlp_pkg::KEY_CHARS_W-1:0]  key_chars,
    input  logic [ohtlp_pkg::KEY_LENGTH_W-1:0] key_length,
    input  logic [ohtlp_pkg::OPCODE_W-1:0]     opcode_value,
    input  logic [ohtlp_pkg::CODE_LEN_W-1:0]   code_length,
    output logic                               done,
    output logic [ohtlp_pkg::STATUS_W-1:0]     status,
    output logic [ohtlp_pkg::OPCODE_W-1:0]     found_opcode,
    output logic [ohtlp_pkg::CODE_LEN_W-1:0]   found_length,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ohtlp_pkg::PADDR_W-1:0]      paddr,
    input  logic [ohtlp_pkg::PDATA_W-1:0]      pwdata,
    output logic [ohtlp_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    import ohtlp_pkg::*;

    localparam int KEY_W  = CHAR_W * MAX_KEY_CHARS;
    localparam int LEN_W  = $clog2(MAX_KEY_CHARS + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > LOAD_LIMIT_W) ? FILL_W : LOAD_LIMIT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    // Slot word: used, deleted, key length, key, opcode, code length.
    localparam int SIZE_LSB = 0;
    localparam int OP_LSB   = SIZE_LSB + CODE_LEN_W;
    localparam int KEY_LSB  = OP_LSB + OPCODE_W;
    localparam int LEN_LSB  = KEY_LSB + KEY_W;
    localparam int DEL_BIT  = LEN_LSB + LEN_W;
    localparam int USED_BIT = DEL_BIT + 1;
    localparam int MEM_W    = USED_BIT + 1;

    top_state_t state_reg, state_next;

    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [OPCODE_W-1:0]     opc_reg, opc_next;
    logic [CODE_LEN_W-1:0]   clen_reg, clen_next;
    logic [IDX_W-1:0]        rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]        chk_addr_reg, chk_addr_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [OPCODE_W-1:0]     hit_op_reg, hit_op_next;
    logic [CODE_LEN_W-1:0]   hit_size_reg, hit_size_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [FILL_W-1:0]       fill_count_reg, fill_count_next;
    logic [LOAD_LIMIT_W-1:0] load_limit_reg, load_limit_next;
    logic                    done_reg, done_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [OPCODE_W-1:0]     found_opcode_reg, found_opcode_next;
    logic [CODE_LEN_W-1:0]   found_length_reg, found_length_next;

    logic                    accept;
    logic [KEY_LENGTH_W-1:0] len_clamped;
    logic [KEY_CHARS_W-1:0]  key_masked;
    logic                    hash_done;
    logic [IDX_W-1:0]        hash_home;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [MEM_W-1:0]        mem_wdata;
    logic                    mem_re;
    logic [MEM_W-1:0]        mem_rdata;

    logic                    slot_used;
    logic                    slot_deleted;
    logic                    probe_match;
    logic                    probe_empty;
    logic                    probe_end;
    logic                    table_full;
    logic                    cfg_write;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Long keys are cut to MAX_KEY_CHARS and bytes past the length ignored.
    always_comb
    begin
        len_clamped = (key_length > KEY_LENGTH_W'(MAX_KEY_CHARS))
                    ? KEY_LENGTH_W'(MAX_KEY_CHARS) : key_length;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_masked[b*CHAR_W +: CHAR_W] = (KEY_LENGTH_W'(b) < len_clamped)
                                           ? key_chars[b*CHAR_W +: CHAR_W] : '0;
        end
    end

    ohtlp_hash #(
        .CAPACITY      (CAPACITY),
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (key_masked[KEY_W-1:0]),
        .len   (LEN_W'(len_clamped)),
        .done  (hash_done),
        .home  (hash_home)
    );

    ohtlp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    // Examine the slot read in the previous cycle.
    always_comb
    begin
        slot_used    = mem_rdata[USED_BIT];
        slot_deleted = mem_rdata[DEL_BIT];
        probe_match  = rd_pend_reg && slot_used
                    && (mem_rdata[LEN_LSB +: LEN_W] == len_reg)
                    && (mem_rdata[KEY_LSB +: KEY_W] == key_reg);
        probe_empty  = rd_pend_reg && !slot_used && !slot_deleted;
        probe_end    = probe_match || probe_empty
                    || (rd_pend_reg && (cnt_reg == IDX_LAST));
        table_full   = (CMP_W'(fill_count_reg) >= CMP_W'(load_limit_reg))
                    || !free_found_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clr_idx_next      = clr_idx_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        len_next          = len_reg;
        opc_next          = opc_reg;
        clen_next         = clen_reg;
        rd_addr_next      = rd_addr_reg;
        chk_addr_next     = chk_addr_reg;
        rd_pend_next      = rd_pend_reg;
        cnt_next          = cnt_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        hit_op_next       = hit_op_reg;
        hit_size_next     = hit_size_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        fill_count_next   = fill_count_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        found_opcode_next = found_opcode_reg;
        found_length_next = found_length_reg;
        mem_we            = 1'b0;
        mem_waddr         = clr_idx_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = command;
                    key_next  = key_masked[KEY_W-1:0];
                    len_next  = LEN_W'(len_clamped);
                    opc_next  = opcode_value;
                    clen_next = code_length;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    rd_addr_next    = hash_home;
                    rd_pend_next    = 1'b0;
                    cnt_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_PROBE:
            begin
                // Reads run one slot ahead of the check; no writes happen here.
                mem_re        = 1'b1;
                rd_addr_next  = (rd_addr_reg == IDX_LAST) ? '0 : rd_addr_reg + IDX_W'(1);
                chk_addr_next = rd_addr_reg;
                rd_pend_next  = 1'b1;
                if (rd_pend_reg)
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (!slot_used && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_addr_reg;
                    end
                end
                if (probe_match)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = chk_addr_reg;
                    hit_op_next   = mem_rdata[OP_LSB +: OPCODE_W];
                    hit_size_next = mem_rdata[SIZE_LSB +: CODE_LEN_W];
                end
            end
            S_FINISH:
            begin
                done_next         = 1'b1;
                status_next       = STAT_NOT_FOUND;
                found_opcode_next = '0;
                found_length_next = '0;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = STAT_DUPLICATE;
                        end
                        else if (table_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next     = STAT_DONE;
                            mem_we          = 1'b1;
                            mem_waddr       = free_idx_reg;
                            mem_wdata       = '0;
                            mem_wdata[USED_BIT]                 = 1'b1;
                            mem_wdata[LEN_LSB +: LEN_W]         = len_reg;
                            mem_wdata[KEY_LSB +: KEY_W]         = key_reg;
                            mem_wdata[OP_LSB +: OPCODE_W]       = opc_reg;
                            mem_wdata[SIZE_LSB +: CODE_LEN_W]   = clen_reg;
                            fill_count_next = fill_count_reg + FILL_W'(1);
                        end
                    end
                    CMD_FIND:
                    begin
                        if (hit_reg)
                        begin
                            status_next       = STAT_DONE;
                            found_opcode_next = hit_op_reg;
                            found_length_next = hit_size_reg;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            status_next        = STAT_DONE;
                            mem_we             = 1'b1;
                            mem_waddr          = hit_idx_reg;
                            mem_wdata          = '0;
                            mem_wdata[DEL_BIT] = 1'b1;
                            if (fill_count_reg != '0)
                            begin
                                fill_count_next = fill_count_reg - FILL_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                endcase
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign cfg_write       = psel && penable && pwrite && pready
                          && (paddr[2] == REG_LOAD_LIMIT);
    assign load_limit_next = cfg_write ? pwdata[LOAD_LIMIT_W-1:0] : load_limit_reg;
    assign prdata          = (paddr[2] == REG_LOAD_LIMIT) ? PDATA_W'(load_limit_reg) : '0;
    assign pready          = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            cnt_reg         <= '0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            fill_count_reg  <= '0;
            load_limit_reg  <= LOAD_LIMIT_RESET;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            rd_pend_reg     <= rd_pend_next;
            cnt_reg         <= cnt_next;
            hit_reg         <= hit_next;
            free_found_reg  <= free_found_next;
            fill_count_reg  <= fill_count_next;
            load_limit_reg  <= load_limit_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        key_reg          <= key_next;
        len_reg          <= len_next;
        opc_reg          <= opc_next;
        clen_reg         <= clen_next;
        rd_addr_reg      <= rd_addr_next;
        chk_addr_reg     <= chk_addr_next;
        hit_idx_reg      <= hit_idx_next;
        hit_op_reg       <= hit_op_next;
        hit_size_reg     <= hit_size_next;
        free_idx_reg     <= free_idx_next;
        status_reg       <= status_next;
        found_opcode_reg <= found_opcode_next;
        found_length_reg <= found_length_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found_opcode = found_opcode_reg;
    assign found_length = found_length_reg;

`ifndef SYNTHESIS
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_FINISH))
        else $error("slot RAM written outside clearing or finishing");

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |-> (state_reg == S_FINISH))
        else $error("result word raised outside the finish step");

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_HASH))
        else $error("accepted command did not enter hashing");

    a_hash_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash unit finished while not awaited");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W + 1)'(fill_count_reg) <= (CMP_W + 1)'(CAPACITY))
        else $error("fill count above capacity");
`endif

endmodule

>>> tb/opcode_hash_table_linear_probe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opcode_hash_table_linear_probe_checker
// Watches the command, result and APB channels of the opcode table. It keeps
// its own copy of the slot table and the load limit, works out the answer to
// every accepted command word, and compares each result word against the
// oldest answer still waiting.
// ----------------------------------------------------------------------------
module opcode_hash_table_linear_probe_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [ohtlp_pkg::CMD_W-1:0]        command,
    input  logic [ohtlp_pkg::KEY_CHARS_W-1:0]  key_chars,
    input  logic [ohtlp_pkg::KEY_LENGTH_W-1:0] key_length,
    input  logic [ohtlp_pkg::OPCODE_W-1:0]     opcode_value,
    input  logic [ohtlp_pkg::CODE_LEN_W-1:0]   code_length,
    input  logic                               done,
    input  logic [ohtlp_pkg::STATUS_W-1:0]     status,
    input  logic [ohtlp_pkg::OPCODE_W-1:0]     found_opcode,
    input  logic [ohtlp_pkg::CODE_LEN_W-1:0]   found_length,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ohtlp_pkg::PADDR_W-1:0]      paddr,
    input  logic [ohtlp_pkg::PDATA_W-1:0]      pwdata,
    input  logic [ohtlp_pkg::PDATA_W-1:0]      prdata,
    input  logic                               pready,
    output int unsigned                        mismatch_count,
    output int unsigned                        answers_pending
);

    import ohtlp_pkg::*;

    localparam int SLOTS = CAPACITY_DEFAULT;
    localparam int KEY_MAX = MAX_KEY_CHARS_DEFAULT;
    localparam logic [PADDR_W-1:0] LOAD_LIMIT_ADDR = {REG_LOAD_LIMIT, 2'b00};

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OPCODE_W-1:0]   opcode;
        logic [CODE_LEN_W-1:0] length;
    } table_answer_t;

    logic [KEY_CHARS_W-1:0]  tbl_key    [SLOTS];
    logic [KEY_LENGTH_W-1:0] tbl_len    [SLOTS];
    logic [OPCODE_W-1:0]     tbl_opcode [SLOTS];
    logic [CODE_LEN_W-1:0]   tbl_size   [SLOTS];
    bit                      tbl_live   [SLOTS];
    bit                      tbl_tomb   [SLOTS];
    int unsigned             live_count;
    logic [LOAD_LIMIT_W-1:0] limit_shadow;

    table_answer_t expected_answers[$];
    table_answer_t oldest;
    int unsigned   error_total;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_total++;
    endtask

    // Applies one command word to the shadow table and returns its answer.
    function automatic table_answer_t compute_table_answer(
        logic [CMD_W-1:0]        cmd,
        logic [KEY_CHARS_W-1:0]  chars,
        logic [KEY_LENGTH_W-1:0] raw_len,
        logic [OPCODE_W-1:0]     op,
        logic [CODE_LEN_W-1:0]   size
    );
        table_answer_t           ans;
        logic [KEY_LENGTH_W-1:0] len;
        logic [KEY_CHARS_W-1:0]  key;
        logic [HASH_W-1:0]       h;
        int unsigned             i;
        int unsigned             idx;
        int unsigned             n;
        int                      hit;
        int                      free_slot;
        bit                      stop;

        ans = '{status: STAT_NOT_FOUND, opcode: '0, length: '0};
        len = (raw_len > KEY_MAX) ? KEY_LENGTH_W'(KEY_MAX) : raw_len;
        key = '0;
        h = '0;
        for (i = 0; i < len; i++)
        begin
            key[i*CHAR_W +: CHAR_W] = chars[i*CHAR_W +: CHAR_W];
            h = h * 31 + HASH_W'(chars[i*CHAR_W +: CHAR_W]);
        end

        // Walk the chain from the home slot; an empty slot ends it, a
        // deleted mark does not, and the first free one is kept for insert.
        idx = int'(h % SLOTS);
        hit = -1;
        free_slot = -1;
        stop = 1'b0;
        for (n = 0; n < SLOTS && !stop; n++)
        begin
            if (tbl_live[idx])
            begin
                if (tbl_len[idx] == len && tbl_key[idx] == key)
                begin
                    hit = int'(idx);
                    stop = 1'b1;
                end
            end
            else
            begin
                if (free_slot < 0)
                    free_slot = int'(idx);
                if (!tbl_tomb[idx])
                    stop = 1'b1;
            end
            idx = (idx + 1) % SLOTS;
        end

        case (cmd)
            CMD_INSERT:
            begin
                if (hit >= 0)
                    ans.status = STAT_DUPLICATE;
                else if (live_count >= limit_shadow || free_slot < 0)
                    ans.status = STAT_FULL;
                else
                begin
                    tbl_key[free_slot] = key;
                    tbl_len[free_slot] = len;
                    tbl_opcode[free_slot] = op;
                    tbl_size[free_slot] = size;
                    tbl_live[free_slot] = 1'b1;
                    tbl_tomb[free_slot] = 1'b0;
                    live_count++;
                    ans.status = STAT_DONE;
                end
            end
            CMD_FIND:
            begin
                if (hit >= 0)
                begin
                    ans.status = STAT_DONE;
                    ans.opcode = tbl_opcode[hit];
                    ans.length = tbl_size[hit];
                end
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    tbl_live[hit] = 1'b0;
                    tbl_tomb[hit] = 1'b1;
                    if (live_count > 0)
                        live_count--;
                    ans.status = STAT_DONE;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_answers.delete();
            for (int s = 0; s < SLOTS; s++)
            begin
                tbl_live[s] = 1'b0;
                tbl_tomb[s] = 1'b0;
            end
            live_count = 0;
            limit_shadow = LOAD_LIMIT_RESET;
            error_total = 0;
            mismatch_count <= 0;
            answers_pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("result word with nothing pending", status, 0);
                else
                begin
                    oldest = expected_answers.pop_front();
                    if (status !== oldest.status)
                        report_mismatch("status", status, oldest.status);
                    if (found_opcode !== oldest.opcode)
                        report_mismatch("found_opcode", found_opcode, oldest.opcode);
                    if (found_length !== oldest.length)
                        report_mismatch("found_length", found_length, oldest.length);
                end
            end
            if (start && !busy)
                expected_answers.push_back(compute_table_answer(command, key_chars,
                    key_length, opcode_value, code_length));
            if (psel && penable && pready && paddr == LOAD_LIMIT_ADDR)
            begin
                if (pwrite)
                    limit_shadow = pwdata[LOAD_LIMIT_W-1:0];
                else if (prdata !== PDATA_W'(limit_shadow))
                    report_mismatch("load_limit read", prdata, limit_shadow);
            end
            mismatch_count <= error_total;
            answers_pending <= expected_answers.size();
        end
    end

endmodule

>>> tb/opcode_hash_table_linear_probe_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opcode_hash_table_linear_probe_tb
// Drives command words into the opcode table with random gaps, moves the load
// limit through its extremes between phases, and leaves prediction and
// comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
module opcode_hash_table_linear_probe_tb;
    import ohtlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] LOAD_LIMIT_ADDR = {REG_LOAD_LIMIT, 2'b00};
    localparam int POOL_MAX = 128;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        command;
    logic [KEY_CHARS_W-1:0]  key_chars;
    logic [KEY_LENGTH_W-1:0] key_length;
    logic [OPCODE_W-1:0]     opcode_value;
    logic [CODE_LEN_W-1:0]   code_length;
    logic                    done;
    logic [STATUS_W-1:0]     status;
    logic [OPCODE_W-1:0]     found_opcode;
    logic [CODE_LEN_W-1:0]   found_length;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    int unsigned mismatch_count;
    int unsigned answers_pending;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 30;

    logic [KEY_CHARS_W-1:0]  pool_chars [POOL_MAX];
    logic [KEY_LENGTH_W-1:0] pool_len   [POOL_MAX];
    int unsigned             pool_size;

    opcode_hash_table_linear_probe dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key_chars    (key_chars),
        .key_length   (key_length),
        .opcode_value (opcode_value),
        .code_length  (code_length),
        .done         (done),
        .status       (status),
        .found_opcode (found_opcode),
        .found_length (found_length),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    opcode_hash_table_linear_probe_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .key_chars       (key_chars),
        .key_length      (key_length),
        .opcode_value    (opcode_value),
        .code_length     (code_length),
        .done            (done),
        .status          (status),
        .found_opcode    (found_opcode),
        .found_length    (found_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("opcode_hash_table_linear_probe_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [KEY_CHARS_W-1:0] char_mask(int unsigned n);
        return (n >= KEY_BYTES) ? '1 : (KEY_CHARS_W'(1) << (CHAR_W * n)) - 1;
    endfunction

    // Presents one command word, after a random gap, and returns at the edge
    // that accepts it with start still high.
    task automatic issue(logic [CMD_W-1:0] cmd, logic [KEY_CHARS_W-1:0] chars,
                         logic [KEY_LENGTH_W-1:0] len, logic [OPCODE_W-1:0] op,
                         logic [CODE_LEN_W-1:0] size);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        key_chars <= chars;
        key_length <= len;
        opcode_value <= op;
        code_length <= size;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(logic write, logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= LOAD_LIMIT_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The block must be idle, so every answer is collected first.
    task automatic set_load_limit(logic [LOAD_LIMIT_W-1:0] limit);
        wait_drained();
        apb_access(1'b1, PDATA_W'(limit));
        apb_access(1'b0, '0);
    endtask

    task automatic build_pool(int unsigned n);
        for (int k = 0; k < n; k++)
        begin
            pool_len[k] = ($urandom_range(0, 19) == 0) ? '0 : KEY_LENGTH_W'($urandom_range(1, 8));
            pool_chars[k] = {$urandom, $urandom} & char_mask(pool_len[k]);
        end
        pool_size = n;
    endtask

    // Mostly keys from the pool with fresh junk in the unused bytes, so that
    // hits, duplicates and removals happen; the rest are arbitrary keys.
    task automatic random_op(int unsigned ins_w, int unsigned find_w, int unsigned rem_w);
        int unsigned             pick;
        int unsigned             k;
        logic [CMD_W-1:0]        cmd;
        logic [KEY_CHARS_W-1:0]  chars;
        logic [KEY_LENGTH_W-1:0] len;

        pick = $urandom_range(0, 99);
        if (pick < ins_w)
            cmd = CMD_INSERT;
        else if (pick < ins_w + find_w)
            cmd = CMD_FIND;
        else if (pick < ins_w + find_w + rem_w)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_UNUSED;
        chars = {$urandom, $urandom};
        if ($urandom_range(0, 9) != 0)
        begin
            k = $urandom_range(0, pool_size - 1);
            len = pool_len[k];
            if (len == KEY_BYTES && $urandom_range(0, 3) == 0)
                len = KEY_LENGTH_W'($urandom_range(9, 15));
            chars = (chars & ~char_mask(pool_len[k])) | pool_chars[k];
        end
        else
            len = KEY_LENGTH_W'($urandom_range(0, 15));
        issue(cmd, chars, len, OPCODE_W'($urandom), CODE_LEN_W'($urandom));
    endtask

    task automatic run_phase(int unsigned words, int unsigned idle, int unsigned ins_w,
                             int unsigned find_w, int unsigned rem_w);
        idle_pct = idle;
        repeat (words) random_op(ins_w, find_w, rem_w);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_INSERT;
        key_chars = '0;
        key_length = '0;
        opcode_value = '0;
        code_length = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, then a chain of single characters that all hash to
        // slot one, with a removal in the middle of the chain.
        issue(CMD_FIND, 64'h01, 4'd1, 16'h0000, 4'h0);
        issue(CMD_REMOVE, 64'h01, 4'd1, 16'h0000, 4'h0);
        issue(CMD_UNUSED, 64'h01, 4'd1, 16'hFFFF, 4'hF);
        issue(CMD_INSERT, 64'hDEAD_BEEF_0BAD_F00D, 4'd0, 16'hFFFF, 4'hF);
        issue(CMD_FIND, 64'h1234_5678_9ABC_DEF0, 4'd0, 16'h0000, 4'h0);
        issue(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF01, 4'd1, 16'h0000, 4'h0);
        issue(CMD_INSERT, 64'h41, 4'd1, 16'hA5A5, 4'h5);
        issue(CMD_INSERT, 64'h81, 4'd1, 16'h5A5A, 4'hA);
        issue(CMD_INSERT, 64'h01, 4'd1, 16'h1111, 4'h1);
        issue(CMD_REMOVE, 64'h41, 4'd1, 16'h0000, 4'h0);
        issue(CMD_FIND, 64'h81, 4'd1, 16'h0000, 4'h0);
        issue(CMD_FIND, 64'h41, 4'd1, 16'h0000, 4'h0);
        issue(CMD_INSERT, 64'hC1, 4'd1, 16'h8001, 4'h8);
        issue(CMD_FIND, 64'hC1, 4'd1, 16'h0000, 4'h0);
        // A length above eight characters is clamped to eight.
        issue(CMD_INSERT, '1, 4'd15, 16'h7FFE, 4'h7);
        issue(CMD_FIND, '1, 4'd8, 16'h0000, 4'h0);
        // Eight zero characters share the empty key's home slot.
        issue(CMD_INSERT, 64'h0, 4'd8, 16'h00FF, 4'h3);
        issue(CMD_FIND, 64'hFF00_0000_0000_0000, 4'd3, 16'h0000, 4'h0);
        issue(CMD_FIND, 64'h0, 4'd9, 16'h0000, 4'h0);
        issue(CMD_REMOVE, '1, 4'd12, 16'h0000, 4'h0);
        issue(CMD_FIND, '1, 4'd8, 16'h0000, 4'h0);

        // A zero limit refuses new keys but still reports a duplicate first.
        set_load_limit(7'd0);
        issue(CMD_INSERT, 64'h02, 4'd1, 16'h0202, 4'h2);
        issue(CMD_INSERT, 64'h01, 4'd1, 16'h0101, 4'h1);
        issue(CMD_FIND, 64'h01, 4'd1, 16'h0000, 4'h0);
        set_load_limit(7'd1);
        issue(CMD_INSERT, 64'h02, 4'd1, 16'h0202, 4'h2);

        // Highest limit: the table fills every slot, then deleted marks pile up.
        set_load_limit(7'd127);
        build_pool(100);
        run_phase(350, 30, 70, 20, 7);
        run_phase(250, 30, 25, 25, 47);

        set_load_limit(7'd64);
        run_phase(350, 0, 45, 30, 22);

        set_load_limit(LOAD_LIMIT_W'($urandom_range(1, 64)));
        build_pool(40);
        run_phase(350, 30, 45, 35, 17);

        set_load_limit(LOAD_LIMIT_RESET);
        build_pool(24);
        run_phase(350, 30, 40, 35, 22);

        set_load_limit(LOAD_LIMIT_W'($urandom_range(0, 127)));
        build_pool(64);
        run_phase(300, 30, 40, 35, 22);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("opcode_hash_table_linear_probe_tb: done, clean");
        else
            $display("opcode_hash_table_linear_probe_tb: done, errors");
        $finish;
    end

endmodule
